@@ src/cjkpt_pkg.sv @@
// Package with the widths, class codes, item types and punctuation table of the pre-tokenizer.
`timescale 1ns / 1ps

package cjkpt_pkg;

    localparam int CP_W  = 21;
    localparam int CLS_W = 2;

    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SPACE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_CJK   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_PUNCT = 2'd3;

    localparam logic [CP_W-1:0] SPACE_CP = 21'd32;

    localparam int N_MARKS = 29;

    typedef logic [CP_W-1:0] cp_t;

    // Full-width and typographic punctuation used in CJK text.
    localparam cp_t CJK_MARKS [N_MARKS] = '{
        21'd8211,  21'd8212,  21'd8216,  21'd8217,  21'd8220,  21'd8221,
        21'd8230,  21'd12289, 21'd12290, 21'd12296, 21'd12297, 21'd12298,
        21'd12299, 21'd12300, 21'd12301, 21'd12302, 21'd12303, 21'd12304,
        21'd12305, 21'd12308, 21'd12309, 21'd65281, 21'd65288, 21'd65289,
        21'd65292, 21'd65294, 21'd65306, 21'd65307, 21'd65311
    };

    // A code point after classification, as it travels from front to back.
    typedef struct packed {
        cp_t              code_point;
        logic             text_end;
        logic [CLS_W-1:0] char_class;
    } cls_item_t;

endpackage

@@ src/cjkpt_ifs.sv @@
// Valid/ready channel interfaces for the input, the internal classified stream and the output.
`timescale 1ns / 1ps

interface cjkpt_in_if;
    logic                  valid;
    logic                  ready;
    cjkpt_pkg::cp_t        code_point;
    logic                  text_end;

    modport source (output valid, code_point, text_end, input ready);
    modport sink   (input valid, code_point, text_end, output ready);
endinterface

interface cjkpt_cls_if;
    logic                  valid;
    logic                  ready;
    cjkpt_pkg::cls_item_t  item;

    modport source (output valid, item, input ready);
    modport sink   (input valid, item, output ready);
endinterface

interface cjkpt_out_if;
    logic                               valid;
    logic                               ready;
    cjkpt_pkg::cp_t                     char_out;
    logic                               kept;
    logic                               token_start;
    logic [cjkpt_pkg::CLS_W-1:0]        char_class;
    logic                               last_of_text;

    modport source (output valid, char_out, kept, token_start, char_class, last_of_text,
                    input ready);
    modport sink   (input valid, char_out, kept, token_start, char_class, last_of_text,
                    output ready);
endinterface

@@ src/cjkpt_front.sv @@
// Front stage: accepts code points, classifies them and registers the classified item.
`timescale 1ns / 1ps

module cjkpt_front (
    input  logic        clk,
    input  logic        rst_n,
    cjkpt_in_if.sink    din,
    cjkpt_cls_if.source cls
);

    logic                        valid_reg;
    cjkpt_pkg::cls_item_t        item_reg;
    logic [cjkpt_pkg::CLS_W-1:0] class_next;
    logic                        is_cjk;
    logic                        is_ascii_punct;
    logic                        is_mark;
    logic                        accept;

    always_comb
    begin
        is_cjk = (din.code_point >= 21'd19968  && din.code_point <= 21'd40959)  ||
                 (din.code_point >= 21'd13312  && din.code_point <= 21'd19903)  ||
                 (din.code_point >= 21'd131072 && din.code_point <= 21'd173791) ||
                 (din.code_point >= 21'd173824 && din.code_point <= 21'd183983) ||
                 (din.code_point >= 21'd63744  && din.code_point <= 21'd64255)  ||
                 (din.code_point >= 21'd194560 && din.code_point <= 21'd195103);

        is_ascii_punct = (din.code_point >= 21'd33  && din.code_point <= 21'd47) ||
                         (din.code_point >= 21'd58  && din.code_point <= 21'd64) ||
                         (din.code_point >= 21'd91  && din.code_point <= 21'd96) ||
                         (din.code_point >= 21'd123 && din.code_point <= 21'd126);

        // Parallel match against every entry of the mark table.
        is_mark = 1'b0;
        for (int k = 0; k < cjkpt_pkg::N_MARKS; k++)
        begin
            if (din.code_point == cjkpt_pkg::CJK_MARKS[k])
            begin
                is_mark = 1'b1;
            end
        end

        if (din.code_point == cjkpt_pkg::SPACE_CP)
        begin
            class_next = cjkpt_pkg::CLS_SPACE;
        end
        else if (is_cjk)
        begin
            class_next = cjkpt_pkg::CLS_CJK;
        end
        else if (is_ascii_punct || is_mark)
        begin
            class_next = cjkpt_pkg::CLS_PUNCT;
        end
        else
        begin
            class_next = cjkpt_pkg::CLS_OTHER;
        end
    end

    assign din.ready = !valid_reg || cls.ready;
    assign accept    = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.code_point <= din.code_point;
            item_reg.text_end   <= din.text_end;
            item_reg.char_class <= class_next;
        end
    end

    assign cls.valid = valid_reg;
    assign cls.item  = item_reg;

endmodule

@@ src/cjkpt_queue.sv @@
// Small FIFO that decouples the classifying front from the token back end.
`timescale 1ns / 1ps

module cjkpt_queue #(
    parameter int DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    cjkpt_cls_if.sink   wr,
    cjkpt_cls_if.source rd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cjkpt_pkg::cls_item_t store_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr.ready = (count_reg != CNT_W'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.item  = store_reg[rd_ptr_reg];

    assign push = wr.valid && wr.ready;
    assign pop  = rd.valid && rd.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

@@ src/cjkpt_back.sv @@
// Back end: tracks word boundaries and registers one result per classified item.
`timescale 1ns / 1ps

module cjkpt_back (
    input  logic        clk,
    input  logic        rst_n,
    cjkpt_cls_if.sink   cls,
    cjkpt_out_if.source dout
);

    logic                        after_boundary_reg;
    logic                        after_boundary_next;
    logic                        out_valid_reg;
    cjkpt_pkg::cp_t              char_reg;
    logic                        kept_reg;
    logic                        start_reg;
    logic [cjkpt_pkg::CLS_W-1:0] class_reg;
    logic                        last_reg;
    logic                        kept_next;
    logic                        start_next;
    logic                        accept;

    assign cls.ready = !out_valid_reg || dout.ready;
    assign accept    = cls.valid && cls.ready;

    always_comb
    begin
        unique case (cls.item.char_class)
            cjkpt_pkg::CLS_SPACE:
            begin
                kept_next           = 1'b0;
                start_next          = 1'b0;
                after_boundary_next = 1'b1;
            end
            cjkpt_pkg::CLS_OTHER:
            begin
                kept_next           = 1'b1;
                start_next          = after_boundary_reg;
                after_boundary_next = 1'b0;
            end
            default:
            begin
                kept_next           = 1'b1;
                start_next          = 1'b1;
                after_boundary_next = 1'b1;
            end
        endcase
        // The next text always starts with a fresh word.
        if (cls.item.text_end)
        begin
            after_boundary_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_boundary_reg <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                after_boundary_reg <= after_boundary_next;
            end
            if (cls.ready)
            begin
                out_valid_reg <= cls.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= cls.item.code_point;
            kept_reg  <= kept_next;
            start_reg <= start_next;
            class_reg <= cls.item.char_class;
            last_reg  <= cls.item.text_end;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.char_out     = char_reg;
    assign dout.kept         = kept_reg;
    assign dout.token_start  = start_reg;
    assign dout.char_class   = class_reg;
    assign dout.last_of_text = last_reg;

endmodule

@@ src/cjk_punct_pretokenizer.sv @@
// Top level of the streaming CJK and punctuation pre-tokenizer.
`timescale 1ns / 1ps

// The block takes one Unicode code point per item and returns exactly one result
// item for it, in order: the code point echoed, its class (other, space, CJK
// ideograph, punctuation), whether it is kept (spaces are dropped), whether it
// starts a new token, and the end-of-text mark. It sustains one item per clock while
// the output is not stalled. An accepted item is registered in turn: in the classifier
// register at the accepting edge, then in the queue and then in the output register.
// The only carried state is the word-boundary flag, updated in the back end once per
// item. Each side may stall on its own: the queue between the classifier and the
// back end holds QUEUE_DEPTH items.
module cjk_punct_pretokenizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    cjkpt_in_if.sink    din,
    cjkpt_out_if.source dout
);

    cjkpt_cls_if front_ch ();
    cjkpt_cls_if back_ch ();

    cjkpt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .cls   (front_ch.source)
    );

    cjkpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_ch.sink),
        .rd    (back_ch.source)
    );

    cjkpt_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cls   (back_ch.sink),
        .dout  (dout)
    );

    // Exactly the spaces are dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.kept == (dout.char_class != cjkpt_pkg::CLS_SPACE)))
        else $error("kept flag disagrees with class");

    // CJK ideographs and punctuation are always tokens of their own.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (dout.char_class == cjkpt_pkg::CLS_CJK ||
                       dout.char_class == cjkpt_pkg::CLS_PUNCT) |-> dout.token_start)
        else $error("single-character token without start mark");

    // Consecutive "other" results inside one word never restart it.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.ready && dout.char_class == cjkpt_pkg::CLS_OTHER &&
        !dout.last_of_text
        ##1 dout.valid && dout.char_class == cjkpt_pkg::CLS_OTHER |-> !dout.token_start)
        else $error("word split without a boundary");

    // The front stage accepts whenever the queue can take its held item.
    assert property (@(posedge clk) disable iff (!rst_n)
        front_ch.ready |-> din.ready)
        else $error("front stalled while queue has room");

endmodule
